### rtl/core/deque_with_reverse_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the deque core
// Each macro is one clocked property that is disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef DEQUE_WITH_REVERSE_ASSERT_SVH
`define DEQUE_WITH_REVERSE_ASSERT_SVH

// Same-cycle implication.
`define DWR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dwr_pkg.sv
// ---------------------------------------------------------------------------
// dwr_pkg
// Defaults, operation codes and status codes of the deque core.
// ---------------------------------------------------------------------------
package dwr_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OP_W           = 3;
  localparam int STATUS_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_QUERY      = 3'd5
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

### rtl/core/deque_with_reverse.sv
// ---------------------------------------------------------------------------
// deque_with_reverse
// Bounded double-ended queue with constant-time reverse, held in a ring RAM.
// ---------------------------------------------------------------------------
// Request channel (req_valid/req_ready) carries op and value; response
// channel (rsp_valid/rsp_ready) returns one result per request: status,
// front_value, back_value, count and is_empty as seen after the operation.
// Both ends of the queue are also held in registers, so pushes, reverse and
// query need no RAM read: the result is registered from the transfer itself,
// and such requests can be taken every cycle while rsp_ready is high.
// A pop that leaves one or more values must fetch the new end word from the
// ring RAM, whose read is registered, so it passes through S_READ, and
// req_ready is low during the read cycle. A pop that empties the queue, or
// hits an empty one, needs no RAM read.
// A request is taken only when the response register is empty or is being
// emptied in the same cycle; a stalled receiver therefore holds back new
// requests while the response waits.
// Reset (rst, synchronous) empties the queue, clears the reverse flag and
// drops any pending response; RAM contents are not cleared.
// ---------------------------------------------------------------------------
`include "deque_with_reverse_assert.svh"

module deque_with_reverse import dwr_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [OP_W-1:0]       op,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [DATA_WIDTH-1:0] front_value,
  output logic [DATA_WIDTH-1:0] back_value,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                  is_empty
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  function automatic logic [IW-1:0] wrap(input logic [IW:0] s);
    logic [IW:0] r;
    r = (s >= DEPTH_X) ? (s - DEPTH_X) : s;
    return r[IW-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  state_t                state;
  logic [IW-1:0]         head, head_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic                  rev, rev_next;
  logic [DATA_WIDTH-1:0] pf, pf_next, pb, pb_next;
  logic                  rd_front;

  logic                  acc, full, empty, is_push, at_front, need_rd, wr_en;
  logic [IW-1:0]         head_inc, head_dec, slot_tail, slot_pre, wr_addr, rd_addr;
  logic [STATUS_W-1:0]   st;

  logic [DATA_WIDTH-1:0] res_pf, res_pb;
  logic [CW-1:0]         res_cnt;
  logic                  res_rev;
  logic [STATUS_W-1:0]   res_st;

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign acc       = req_valid && req_ready;
  assign full      = (cnt == CNT_FULL);
  assign empty     = (cnt == '0);
  assign is_push   = (op_t'(op) == OP_PUSH_FRONT) || (op_t'(op) == OP_PUSH_BACK);
  assign at_front  = ((op_t'(op) == OP_PUSH_FRONT) || (op_t'(op) == OP_POP_FRONT)) != rev;
  assign head_inc  = (head == LAST_IDX) ? '0 : head + IW'(1);
  assign head_dec  = (head == '0) ? LAST_IDX : head - IW'(1);
  assign slot_tail = wrap({1'b0, head} + (IW + 1)'(cnt));
  assign slot_pre  = wrap({1'b0, head} + (IW + 1)'(cnt) - (IW + 1)'(2));

  always_comb begin
    head_next = head;
    cnt_next  = cnt;
    rev_next  = rev;
    pf_next   = pf;
    pb_next   = pb;
    st        = ST_OK;
    wr_en     = 1'b0;
    wr_addr   = slot_tail;
    rd_addr   = head_inc;
    need_rd   = 1'b0;
    case (op_t'(op))
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          wr_en    = 1'b1;
          cnt_next = cnt + CW'(1);
          if (at_front) begin
            head_next = head_dec;
            wr_addr   = head_dec;
            pf_next   = value;
            if (empty) pb_next = value;
          end else begin
            pb_next = value;
            if (empty) pf_next = value;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          cnt_next = cnt - CW'(1);
          if (at_front) head_next = head_inc;
          rd_addr = at_front ? head_inc : slot_pre;
          need_rd = (cnt != CW'(1));
        end
      end
      OP_REVERSE: begin
        rev_next = !rev;
      end
      default: ;
    endcase
  end

  // Ring RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (acc && wr_en) mem[wr_addr] <= value;
    rd_data <= mem[rd_addr];
  end

  // Result source: fresh RAM word after a pop read, else the new state
  always_comb begin
    if (state == S_READ) begin
      res_pf  = rd_front ? rd_data : pf;
      res_pb  = rd_front ? pb : rd_data;
      res_cnt = cnt;
      res_rev = rev;
      res_st  = ST_OK;
    end else begin
      res_pf  = pf_next;
      res_pb  = pb_next;
      res_cnt = cnt_next;
      res_rev = rev_next;
      res_st  = st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      cnt       <= '0;
      rev       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        head  <= head_next;
        cnt   <= cnt_next;
        rev   <= rev_next;
        state <= need_rd ? S_READ : S_IDLE;
      end else if (state == S_READ) begin
        state <= S_IDLE;
      end
      if ((acc && !need_rd) || (state == S_READ)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pf       <= pf_next;
      pb       <= pb_next;
      rd_front <= at_front;
    end else if (state == S_READ) begin
      pf <= res_pf;
      pb <= res_pb;
    end
    if ((acc && !need_rd) || (state == S_READ)) begin
      status   <= res_st;
      count    <= res_cnt;
      is_empty <= (res_cnt == '0);
      if (res_cnt == '0) begin
        front_value <= '0;
        back_value  <= '0;
      end else begin
        front_value <= res_rev ? res_pb : res_pf;
        back_value  <= res_rev ? res_pf : res_pb;
      end
    end
  end

  `DWR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CNT_FULL, "stored count exceeds depth")
  `DWR_ASSERT_NEXT(a_read_lands, state == S_READ, rsp_valid && state == S_IDLE,
    "pop read did not produce a response")
  `DWR_ASSERT_NEXT(a_full_drop, acc && is_push && full,
    $stable(cnt) && status == ST_FULL, "push on full changed the queue")
  `DWR_ASSERT_NOW(a_empty_flag, rsp_valid, is_empty == (count == '0),
    "empty flag disagrees with count")

endmodule
